// ----- rtl/pbd_pkg.sv -----
package pbd_pkg;

	localparam int HISTORY_DEPTH = 10;
	localparam int SAMPLE_BITS = 8;
	localparam int ELAPSED_BITS = 12;
	localparam int BPM_BITS = 8;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = 12'd4095;
	localparam logic [ELAPSED_BITS-1:0] SEED_INTERVAL = 12'd600;
	localparam int MS_PER_MINUTE = 60000;
	localparam int QUOT_BITS = 16;
	localparam int SUM_BITS = 16;

	localparam logic [3:0] TICK_RESET = 4'd2;
	localparam logic [9:0] HOLDOFF_RESET = 10'd250;
	localparam logic [11:0] TIMEOUT_RESET = 12'd2500;
	localparam logic [7:0] FLOOR_RESET = 8'd60;
	localparam logic [7:0] CEILING_RESET = 8'd150;

	localparam logic [2:0] REG_TICK = 3'd0;
	localparam logic [2:0] REG_HOLDOFF = 3'd1;
	localparam logic [2:0] REG_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_FLOOR = 3'd3;
	localparam logic [2:0] REG_CEILING = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SHIFT,
		ST_MEAN,
		ST_DIVIDE,
		ST_FINISH,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic shift;
		logic mean;
		logic div_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic counted_beat;
		logic shift_done;
		logic div_done;
	} status_t;

endpackage

// ----- rtl/pbd_ctrl.sv -----
module pbd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  pbd_pkg::status_t   status,
	output pbd_pkg::cmd_t      cmd
);

	pbd_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			pbd_pkg::ST_IDLE: begin
				if (in_valid) state_next = pbd_pkg::ST_UPDATE;
			end
			pbd_pkg::ST_UPDATE: begin
				state_next = status.counted_beat ? pbd_pkg::ST_SHIFT : pbd_pkg::ST_OUTPUT;
			end
			pbd_pkg::ST_SHIFT: begin
				if (status.shift_done) state_next = pbd_pkg::ST_MEAN;
			end
			pbd_pkg::ST_MEAN: state_next = pbd_pkg::ST_DIVIDE;
			pbd_pkg::ST_DIVIDE: begin
				if (status.div_done) state_next = pbd_pkg::ST_FINISH;
			end
			pbd_pkg::ST_FINISH: state_next = pbd_pkg::ST_OUTPUT;
			pbd_pkg::ST_OUTPUT: begin
				if (!out_stall) state_next = pbd_pkg::ST_IDLE;
			end
			default: state_next = pbd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			pbd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			pbd_pkg::ST_UPDATE: cmd.update = 1'b1;
			pbd_pkg::ST_SHIFT: cmd.shift = 1'b1;
			pbd_pkg::ST_MEAN: begin
				cmd.mean = 1'b1;
				cmd.div_start = 1'b1;
			end
			pbd_pkg::ST_DIVIDE: ;
			pbd_pkg::ST_FINISH: cmd.finish = 1'b1;
			pbd_pkg::ST_OUTPUT: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

// ----- rtl/pbd_datapath.sv -----
module pbd_datapath #(
	parameter int HISTORY_DEPTH = pbd_pkg::HISTORY_DEPTH,
	parameter int SAMPLE_BITS = pbd_pkg::SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pbd_pkg::cmd_t          cmd,
	output pbd_pkg::status_t       status,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [3:0]             tick_period_ms,
	input  logic [9:0]             holdoff_ms,
	input  logic [11:0]            silence_timeout_ms,
	input  logic [7:0]             rate_floor,
	input  logic [7:0]             rate_ceiling,
	output logic                   beat,
	output logic [7:0]             bpm,
	output logic [7:0]             heart_rate,
	output logic [11:0]            interval_ms,
	output logic                   pulse_high,
	output logic [9:0]             threshold
);

	localparam int LB = SAMPLE_BITS + 2;
	localparam int EB = pbd_pkg::ELAPSED_BITS;
	localparam int HB = $clog2(HISTORY_DEPTH);
	localparam int CB = $clog2(HISTORY_DEPTH + 1);
	localparam int QB = pbd_pkg::QUOT_BITS;
	localparam int SB = EB + CB;
	localparam logic [LB-1:0] SEED_LEVEL = LB'(1) << (SAMPLE_BITS + 1);
	localparam logic [CB-1:0] HLAST = CB'(HISTORY_DEPTH - 1);
	localparam int G_SHIFT = EB + 3;
	localparam logic [EB:0] FIFTH_RECIP = (EB+1)'(((1 << G_SHIFT) + 4) / 5);
	localparam int RS = SB + HB;
	localparam logic [SB:0] MEAN_RECIP =
		(SB+1)'(((64'd1 << RS) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

	logic [LB-1:0] level_q, peak_q, trough_q, detect_q;
	logic [EB-1:0] elapsed_q, interval_q;
	logic [EB-1:0] hist_q [HISTORY_DEPTH];
	logic          above_q, first_q, second_q, beat_q;
	logic [7:0]    bpm_q, rate_q;
	logic [CB-1:0] idx_q;
	logic [SB-1:0] total_q;
	logic [QB-1:0] mean_q;
	logic [QB-1:0] quot_q;
	logic [QB:0]   rem_q;
	logic [4:0]    bit_q;
	logic          busy_q;

	logic [EB:0]   n_wide;
	logic [EB-1:0] n;
	logic [2*EB:0] fifth_prod;
	logic [EB-1:0] fifth;
	logic [EB-1:0] guard;
	logic [2*SB:0] mean_prod;
	logic          below, above, fire, first_discard;
	logic [QB:0]   rem_try;
	logic [QB-1:0] num;

	assign n_wide = {1'b0, elapsed_q} + (EB+1)'(tick_period_ms);
	assign n = n_wide[EB] ? pbd_pkg::ELAPSED_MAX : n_wide[EB-1:0];
	assign fifth_prod = (2*EB+1)'(interval_q) * (2*EB+1)'(FIFTH_RECIP);
	assign fifth = EB'(fifth_prod >> G_SHIFT);
	assign guard = (fifth << 1) + fifth;
	assign mean_prod = (2*SB+1)'(total_q) * (2*SB+1)'(MEAN_RECIP);
	assign below = level_q < detect_q;
	assign above = level_q > detect_q;
	assign fire = (n > EB'(holdoff_ms)) && above && !above_q && (n > guard);
	assign first_discard = fire && first_q;
	assign num = QB'(pbd_pkg::MS_PER_MINUTE);
	assign rem_try = {rem_q[QB-1:0], num[bit_q[3:0]]} - {1'b0, mean_q};

	assign status.counted_beat = fire && !first_q;
	assign status.shift_done = (idx_q == HLAST);
	assign status.div_done = busy_q && (bit_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= SEED_LEVEL;
			trough_q <= SEED_LEVEL;
			detect_q <= SEED_LEVEL;
			elapsed_q <= '0;
			interval_q <= pbd_pkg::SEED_INTERVAL;
			above_q <= 1'b0;
			first_q <= 1'b1;
			second_q <= 1'b0;
			bpm_q <= '0;
			rate_q <= '0;
			beat_q <= 1'b0;
			busy_q <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else begin
			if (cmd.load) begin
				beat_q <= 1'b0;
			end
			if (cmd.update) begin
				logic       ab;
				logic [LB-1:0] pk, tr, dt;
				logic [LB:0]   am;
				ab = above_q;
				pk = peak_q;
				tr = trough_q;
				dt = detect_q;
				elapsed_q <= n;
				if (below && n > guard && level_q < trough_q) tr = level_q;
				if (above && level_q > peak_q) pk = level_q;
				if (fire) begin
					ab = 1'b1;
					interval_q <= n;
					elapsed_q <= '0;
					if (second_q) begin
						second_q <= 1'b0;
						for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= n;
					end
					if (first_q) begin
						first_q <= 1'b0;
						second_q <= 1'b1;
					end
				end
				am = {1'b0, pk} - {1'b0, tr};
				if (!first_discard) begin
					if (below && ab) begin
						ab = 1'b0;
						dt = LB'($signed(am) / 2) + tr;
						pk = dt;
						tr = dt;
					end
					if (n > silence_timeout_ms) begin
						pk = SEED_LEVEL;
						tr = SEED_LEVEL;
						dt = SEED_LEVEL;
						elapsed_q <= '0;
						first_q <= 1'b1;
						second_q <= 1'b0;
					end
				end
				above_q <= ab;
				peak_q <= pk;
				trough_q <= tr;
				detect_q <= dt;
			end
			if (cmd.shift) begin
				if (idx_q == HLAST) hist_q[HISTORY_DEPTH-1] <= interval_q;
				else hist_q[idx_q[HB-1:0]] <= hist_q[idx_q[HB-1:0] + HB'(1)];
			end
			if (cmd.div_start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 5'd0) begin
				busy_q <= 1'b0;
			end
			if (cmd.finish) begin
				logic [QB-1:0] raw;
				raw = (mean_q == '0) ? QB'(255) : quot_q;
				bpm_q <= (raw > QB'(255)) ? 8'd255 : raw[7:0];
				rate_q <= (raw >= QB'(rate_floor) && raw <= QB'(rate_ceiling)) ?
					raw[7:0] : 8'd0;
				beat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			level_q <= LB'(sample) << 2;
			idx_q <= '0;
			total_q <= '0;
		end
		if (cmd.shift) begin
			idx_q <= idx_q + CB'(1);
			if (idx_q == HLAST) total_q <= total_q + SB'(interval_q);
			else total_q <= total_q + SB'(hist_q[idx_q[HB-1:0] + HB'(1)]);
		end
		if (cmd.mean) begin
			mean_q <= QB'(mean_prod >> RS);
			rem_q <= '0;
			quot_q <= '0;
			bit_q <= 5'(QB - 1);
		end else if (busy_q) begin
			if (!rem_try[QB]) begin
				rem_q <= rem_try;
				quot_q <= {quot_q[QB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[QB-1:0], num[bit_q[3:0]]};
				quot_q <= {quot_q[QB-2:0], 1'b0};
			end
			if (bit_q != 5'd0) bit_q <= bit_q - 5'd1;
		end
	end

	assign beat = beat_q;
	assign bpm = bpm_q;
	assign heart_rate = rate_q;
	assign interval_ms = interval_q;
	assign pulse_high = above_q;
	assign threshold = detect_q[9:0];

endmodule

// ----- rtl/pbd_regs.sv -----
module pbd_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  tick_period_ms,
	output logic [9:0]  holdoff_ms,
	output logic [11:0] silence_timeout_ms,
	output logic [7:0]  rate_floor,
	output logic [7:0]  rate_ceiling
);

	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_ms <= pbd_pkg::TICK_RESET;
			holdoff_ms <= pbd_pkg::HOLDOFF_RESET;
			silence_timeout_ms <= pbd_pkg::TIMEOUT_RESET;
			rate_floor <= pbd_pkg::FLOOR_RESET;
			rate_ceiling <= pbd_pkg::CEILING_RESET;
		end else if (wr) begin
			unique case (idx)
				pbd_pkg::REG_TICK: tick_period_ms <= pwdata[3:0];
				pbd_pkg::REG_HOLDOFF: holdoff_ms <= pwdata[9:0];
				pbd_pkg::REG_TIMEOUT: silence_timeout_ms <= pwdata[11:0];
				pbd_pkg::REG_FLOOR: rate_floor <= pwdata[7:0];
				pbd_pkg::REG_CEILING: rate_ceiling <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			pbd_pkg::REG_TICK: prdata = 32'(tick_period_ms);
			pbd_pkg::REG_HOLDOFF: prdata = 32'(holdoff_ms);
			pbd_pkg::REG_TIMEOUT: prdata = 32'(silence_timeout_ms);
			pbd_pkg::REG_FLOOR: prdata = 32'(rate_floor);
			pbd_pkg::REG_CEILING: prdata = 32'(rate_ceiling);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/pulse_beat_detector_core.sv -----
// channel   direction  handshake                  payload
// sample    in         sample_valid/sample_stall   sample
// result    out        result_valid/result_stall   beat bpm heart_rate interval_ms
//                                                  pulse_high threshold
// config    in         APB psel/penable/pwrite     paddr pwdata prdata
// A sample without a counted beat goes through accept, update and result.
// A counted beat adds a history shift over HISTORY_DEPTH entries, a mean step,
// a 16-bit restoring divider and a finish step before the result.
// One sample is in flight at a time; the next is taken once the result leaves.
// A stalled result holds; reset restores the seeds.
module pulse_beat_detector_core #(
	parameter int HISTORY_DEPTH = pbd_pkg::HISTORY_DEPTH,
	parameter int SAMPLE_BITS = pbd_pkg::SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   beat,
	output logic [7:0]             bpm,
	output logic [7:0]             heart_rate,
	output logic [11:0]            interval_ms,
	output logic                   pulse_high,
	output logic [9:0]             threshold
);

	logic [3:0]  tick_period_ms;
	logic [9:0]  holdoff_ms;
	logic [11:0] silence_timeout_ms;
	logic [7:0]  rate_floor, rate_ceiling;
	pbd_pkg::cmd_t    cmd;
	pbd_pkg::status_t status;

	pbd_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.tick_period_ms, .holdoff_ms, .silence_timeout_ms, .rate_floor, .rate_ceiling
	);

	pbd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(sample_valid), .in_stall(sample_stall),
		.out_valid(result_valid), .out_stall(result_stall),
		.status, .cmd
	);

	pbd_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .status, .sample,
		.tick_period_ms, .holdoff_ms, .silence_timeout_ms, .rate_floor, .rate_ceiling,
		.beat, .bpm, .heart_rate, .interval_ms, .pulse_high, .threshold
	);

endmodule
